// ===== design/stepper_clock_controller_top_assert.svh =====
// Assertion macros for the stepper clock controller
`ifndef STEPPER_CLOCK_CONTROLLER_TOP_ASSERT_SVH
`define STEPPER_CLOCK_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SCC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCC_ASSERT(lbl, ante, cons, msg)
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/scc_pkg.sv =====
`default_nettype none

package scc_pkg;

    localparam int StepsRevDefault = 4080;
    localparam int SecPerHour      = 3600;
    localparam int SecPer12h       = 12 * 3600;

    localparam logic [7:0]  DEBOUNCE_RESET   = 8'd20;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd2000;
    localparam logic [7:0]  STEP_DELAY_RESET = 8'd3;
    localparam logic [9:0]  MS_PER_SEC_RESET = 10'd1000;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_STEP_DELAY = 2'd2,
        CFG_MS_PER_SEC = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_RUN     = 2'd0,
        MODE_EDIT_S  = 2'd1,
        MODE_EDIT_M  = 2'd2,
        MODE_EDIT_H  = 2'd3
    } clock_mode_t;

    typedef struct packed {
        logic short_p;
        logic long_p;
    } press_t;

    function automatic logic [3:0] half_step(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== design/stepper_clock_controller_top.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall   | button_level
// out     | output    | out_valid / out_stall | coils, clock_mode, short_press, long_press, busy_res
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One tick item per clock cycle sustained while the result is not stalled; the
// accepting edge loads the input register, and the result register is then loaded from one pass of logic.
// Reset restores register defaults and clears all clock and motor state.
// A stalled result holds; the input register still fills behind it, and the
// input stalls only while both registers are full.
`default_nettype none

`include "stepper_clock_controller_top_assert.svh"

module stepper_clock_controller_top
    import scc_pkg::*;
#(
    parameter int STEPS_REV = StepsRevDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        button_level,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      coils,
    output logic [1:0]       clock_mode,
    output logic             short_press,
    output logic             long_press,
    output logic             busy_res,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam logic [15:0] SecInc     = 16'(STEPS_REV / 60);
    localparam logic [15:0] HourMinInc = 16'(STEPS_REV / 720);
    localparam logic [15:0] HourInc    = 16'(STEPS_REV / 12);
    localparam int          MinSteps   = STEPS_REV / SecPerHour + 1;
    localparam logic [16:0] StepsAdd   = 17'(STEPS_REV);
    localparam logic [16:0] HourDiv    = 17'(SecPerHour);
    localparam logic [16:0] HalfDayDiv = 17'(SecPer12h);

    logic [7:0]  debounce_reg;
    logic [15:0] long_press_reg;
    logic [7:0]  step_delay_reg;
    logic [9:0]  ms_per_sec_reg;

    logic        s1_valid_reg;
    logic        s1_level_reg;
    logic        s1_go;

    logic        out_valid_reg;
    logic [11:0] coils_reg;
    logic [1:0]  mode_out_reg;
    logic        short_reg;
    logic        long_reg;
    logic        busy_reg;

    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  phase_reg [3];
    logic [2:0]  phase_next [3];
    logic [15:0] pending_reg [3];
    logic [15:0] pending_next [3];
    logic [11:0] minute_rem_reg, minute_rem_next;
    logic [15:0] hour_rem_reg, hour_rem_next;
    logic [9:0]  ms_count_reg, ms_count_next;
    logic [7:0]  step_timer_reg, step_timer_next;
    logic [11:0] coil_reg, coil_next;
    logic        busy_next;

    press_t      bres;

    assign cfg_ready   = 1'b1;
    assign s1_go       = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = s1_valid_reg && !s1_go;
    assign out_valid   = out_valid_reg;
    assign coils       = coils_reg;
    assign clock_mode  = mode_out_reg;
    assign short_press = short_reg;
    assign long_press  = long_reg;
    assign busy_res    = busy_reg;

    scc_button u_button (
        .clk             (clk),
        .rst_n           (rst_n),
        .go              (s1_go),
        .sample          (s1_level_reg),
        .debounce_ticks  (debounce_reg),
        .long_hold_ticks (long_press_reg),
        .press           (bres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            step_delay_reg <= STEP_DELAY_RESET;
            ms_per_sec_reg <= MS_PER_SEC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data[7:0];
                CFG_LONG_PRESS: long_press_reg <= cfg_data;
                CFG_STEP_DELAY: step_delay_reg <= cfg_data[7:0];
                CFG_MS_PER_SEC: ms_per_sec_reg <= cfg_data[9:0];
                default:        debounce_reg   <= debounce_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [15:0] inc [3];
        logic [16:0] sum;
        logic [10:0] cnt;
        logic        sec_evt;
        logic [16:0] mrem;
        logic [16:0] hrem;
        logic [15:0] mq;
        logic        step;

        for (int m = 0; m < 3; m++)
        begin
            inc[m]        = '0;
            phase_next[m] = phase_reg[m];
        end
        mq              = '0;
        mrem            = {5'd0, minute_rem_reg};
        hrem            = {1'b0, hour_rem_reg};
        minute_rem_next = minute_rem_reg;
        hour_rem_next   = hour_rem_reg;

        mode_next = mode_reg + {1'b0, bres.long_p};

        if (bres.short_p)
        begin
            case (clock_mode_t'(mode_next))
                MODE_EDIT_S: inc[0] = SecInc;
                MODE_EDIT_M:
                begin
                    inc[1] = SecInc;
                    inc[2] = HourMinInc;
                end
                MODE_EDIT_H: inc[2] = HourInc;
                default:     inc[0] = '0;
            endcase
        end

        cnt           = {1'b0, ms_count_reg} + 11'd1;
        sec_evt       = cnt >= {1'b0, ms_per_sec_reg};
        ms_count_next = sec_evt ? '0 : cnt[9:0];

        if (sec_evt)
        begin
            if (mode_next != MODE_EDIT_S)
            begin
                inc[0] = SecInc;
            end
            if (mode_next == MODE_RUN)
            begin
                mrem = mrem + StepsAdd;
                for (int i = 0; i < MinSteps; i++)
                begin
                    if (mrem >= HourDiv)
                    begin
                        mrem = mrem - HourDiv;
                        mq   = mq + 16'd1;
                    end
                end
                inc[1]          = mq;
                minute_rem_next = mrem[11:0];
                hrem = hrem + StepsAdd;
                if (hrem >= HalfDayDiv)
                begin
                    hrem   = hrem - HalfDayDiv;
                    inc[2] = 16'd1;
                end
                hour_rem_next = hrem[15:0];
            end
        end

        for (int m = 0; m < 3; m++)
        begin
            sum             = {1'b0, pending_reg[m]} + {1'b0, inc[m]};
            pending_next[m] = sum[16] ? 16'hFFFF : sum[15:0];
        end

        step_timer_next = step_timer_reg;
        if (step_timer_next != 8'd0)
        begin
            step_timer_next = step_timer_next - 8'd1;
        end
        step = (step_timer_next == 8'd0) &&
               ((pending_next[0] | pending_next[1] | pending_next[2]) != 16'd0);

        coil_next = coil_reg;
        if (step)
        begin
            for (int m = 0; m < 3; m++)
            begin
                if (pending_next[m] != 16'd0)
                begin
                    coil_next[4*m +: 4] = half_step(phase_reg[m]);
                    phase_next[m]       = phase_reg[m] + 3'd1;
                    pending_next[m]     = pending_next[m] - 16'd1;
                end
            end
            step_timer_next = step_delay_reg;
        end

        busy_next = (pending_next[0] | pending_next[1] | pending_next[2]) != 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_RUN;
            minute_rem_reg <= '0;
            hour_rem_reg   <= '0;
            ms_count_reg   <= '0;
            step_timer_reg <= '0;
            coil_reg       <= '0;
            for (int m = 0; m < 3; m++)
            begin
                phase_reg[m]   <= '0;
                pending_reg[m] <= '0;
            end
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                mode_reg       <= mode_next;
                minute_rem_reg <= minute_rem_next;
                hour_rem_reg   <= hour_rem_next;
                ms_count_reg   <= ms_count_next;
                step_timer_reg <= step_timer_next;
                coil_reg       <= coil_next;
                for (int m = 0; m < 3; m++)
                begin
                    phase_reg[m]   <= phase_next[m];
                    pending_reg[m] <= pending_next[m];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_level_reg <= button_level;
        end
        if (s1_go)
        begin
            coils_reg    <= coil_next;
            mode_out_reg <= mode_next;
            short_reg    <= bres.short_p;
            long_reg     <= bres.long_p;
            busy_reg     <= busy_next;
        end
    end

    `SCC_ASSERT_NEXT(a_mode_only_on_long, s1_go && !bres.long_p, $stable(mode_reg), "mode moved without long press")
    `SCC_ASSERT_NEXT(a_busy_matches, s1_go, busy_reg == ((pending_reg[0] | pending_reg[1] | pending_reg[2]) != 16'd0), "busy flag mismatch")
    `SCC_ASSERT_NEXT(a_result_held, out_valid_reg && out_stall, out_valid_reg && $stable(coils_reg), "stalled result lost")
    `SCC_ASSERT(a_out_matches_state, out_valid_reg, coils_reg == coil_reg && mode_out_reg == mode_reg, "result apart from state")

endmodule

`default_nettype wire

// ===== design/scc_button.sv =====
`default_nettype none

`include "stepper_clock_controller_top_assert.svh"

module scc_button
    import scc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic        sample,
    input  wire logic [7:0]  debounce_ticks,
    input  wire logic [15:0] long_hold_ticks,
    output press_t           press
);

    logic        raw_reg, raw_next;
    logic        stable_reg, stable_next;
    logic [15:0] since_reg, since_next;
    logic [15:0] ptime_reg, ptime_next;
    logic        long_seen_reg, long_seen_next;

    always_comb
    begin
        raw_next       = raw_reg;
        stable_next    = stable_reg;
        since_next     = since_reg;
        ptime_next     = ptime_reg;
        long_seen_next = long_seen_reg;
        press          = '0;

        if (stable_reg && ptime_reg != 16'hFFFF)
        begin
            ptime_next = ptime_reg + 16'd1;
        end
        if (sample != raw_reg)
        begin
            raw_next   = sample;
            since_next = '0;
        end
        else if (since_reg != 16'hFFFF)
        begin
            since_next = since_reg + 16'd1;
        end
        if (since_next >= {8'd0, debounce_ticks} && stable_reg != sample)
        begin
            stable_next = sample;
            if (sample)
            begin
                ptime_next     = '0;
                long_seen_next = 1'b0;
            end
            else if (!long_seen_reg)
            begin
                press.short_p = 1'b1;
            end
        end
        if (stable_next && !long_seen_next && ptime_next >= long_hold_ticks)
        begin
            long_seen_next = 1'b1;
            press.long_p   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg       <= 1'b0;
            stable_reg    <= 1'b0;
            since_reg     <= '0;
            ptime_reg     <= '0;
            long_seen_reg <= 1'b0;
        end
        else if (go)
        begin
            raw_reg       <= raw_next;
            stable_reg    <= stable_next;
            since_reg     <= since_next;
            ptime_reg     <= ptime_next;
            long_seen_reg <= long_seen_next;
        end
    end

    `SCC_ASSERT_NEXT(a_long_marks_seen, go && press.long_p, long_seen_reg, "long press not latched")
    `SCC_ASSERT(a_short_needs_release, press.short_p, !sample && stable_reg, "short press without release")
    `SCC_ASSERT(a_one_press_kind, go, !(press.short_p && press.long_p), "short and long together")

endmodule

`default_nettype wire

// ===== bench/stepper_clock_controller_top_test.sv =====
`timescale 1ns / 1ps

module stepper_clock_controller_top_test;
    import scc_pkg::*;

    localparam int STEPS_REV = StepsRevDefault;
    localparam int STALL_LIMIT = 4000;
    localparam bit [3:0] HALF_STEP [8] = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

    typedef struct {
        bit [11:0]   coils;
        clock_mode_t mode;
        bit          short_p;
        bit          long_p;
        bit          busy;
    } tick_result_t;

    class tick_scoreboard;
        int unsigned debounce, long_ms, step_delay, ms_per_sec;
        bit raw_last, stable, long_seen;
        int unsigned since_change, press_time, minute_rem, hour_rem, ms_count, step_timer;
        clock_mode_t mode;
        bit [2:0] phase [3];
        int unsigned pending_steps [3];
        bit [11:0] coil;
        tick_result_t expected_ticks [$];
        int failures;

        function new();
            debounce = 32'(DEBOUNCE_RESET);
            long_ms = 32'(LONG_PRESS_RESET);
            step_delay = 32'(STEP_DELAY_RESET);
            ms_per_sec = 32'(MS_PER_SEC_RESET);
            raw_last = 0;
            stable = 0;
            long_seen = 0;
            since_change = 0;
            press_time = 0;
            minute_rem = 0;
            hour_rem = 0;
            ms_count = 0;
            step_timer = 0;
            mode = MODE_RUN;
            coil = '0;
            failures = 0;
            for (int m = 0; m < 3; m++)
            begin
                phase[m] = '0;
                pending_steps[m] = 0;
            end
        endfunction

        function void write_register(cfg_index_t idx, bit [15:0] val);
            case (idx)
                CFG_DEBOUNCE:   debounce = 32'(val[7:0]);
                CFG_LONG_PRESS: long_ms = 32'(val);
                CFG_STEP_DELAY: step_delay = 32'(val[7:0]);
                CFG_MS_PER_SEC: ms_per_sec = 32'(val[9:0]);
                default: ;
            endcase
        endfunction

        function void add_steps(int m, int unsigned n);
            int unsigned s;
            s = pending_steps[m] + n;
            pending_steps[m] = (s > 32'hFFFF) ? 32'hFFFF : s;
        endfunction

        function void note_tick(bit sample);
            tick_result_t r;
            bit sp;
            bit lp;
            logic [1:0] next_mode;
            sp = 0;
            lp = 0;
            if (stable && press_time < 32'hFFFF)
                press_time++;
            if (sample != raw_last)
            begin
                raw_last = sample;
                since_change = 0;
            end
            else if (since_change < 32'hFFFF)
                since_change++;
            if (since_change >= debounce && stable != sample)
            begin
                stable = sample;
                if (sample)
                begin
                    press_time = 0;
                    long_seen = 0;
                end
                else if (!long_seen)
                    sp = 1;
            end
            if (stable && !long_seen && press_time >= long_ms)
            begin
                long_seen = 1;
                lp = 1;
            end
            if (lp)
            begin
                next_mode = mode + 2'd1;
                mode = clock_mode_t'(next_mode);
            end
            if (sp)
            begin
                if (mode == MODE_EDIT_S)
                    add_steps(0, STEPS_REV / 60);
                else if (mode == MODE_EDIT_M)
                begin
                    add_steps(1, STEPS_REV / 60);
                    add_steps(2, STEPS_REV / 720);
                end
                else if (mode == MODE_EDIT_H)
                    add_steps(2, STEPS_REV / 12);
            end
            ms_count = (ms_count + 1) & 32'h7FF;
            if (ms_count >= ms_per_sec)
            begin
                ms_count = 0;
                if (mode != MODE_EDIT_S)
                    add_steps(0, STEPS_REV / 60);
                if (mode == MODE_RUN)
                begin
                    minute_rem += STEPS_REV;
                    add_steps(1, minute_rem / 3600);
                    minute_rem %= 3600;
                    hour_rem += STEPS_REV;
                    add_steps(2, hour_rem / (12 * 3600));
                    hour_rem %= 12 * 3600;
                end
            end
            if (step_timer > 0)
                step_timer--;
            if (step_timer == 0 && (pending_steps[0] | pending_steps[1] | pending_steps[2]) != 0)
            begin
                for (int m = 0; m < 3; m++)
                begin
                    if (pending_steps[m] != 0)
                    begin
                        coil[4 * m +: 4] = HALF_STEP[phase[m]];
                        phase[m] = phase[m] + 3'd1;
                        pending_steps[m]--;
                    end
                end
                step_timer = step_delay;
            end
            r.coils = coil;
            r.mode = mode;
            r.short_p = sp;
            r.long_p = lp;
            r.busy = (pending_steps[0] | pending_steps[1] | pending_steps[2]) != 0;
            expected_ticks.push_back(r);
        endfunction

        function void check_tick(logic [11:0] c, logic [1:0] md, logic sp, logic lp, logic bz);
            tick_result_t e;
            if (expected_ticks.size() == 0)
            begin
                $error("unexpected result item: coils %h", c);
                failures++;
                return;
            end
            e = expected_ticks.pop_front();
            if (c !== e.coils)
            begin
                $error("coils: expected %h, actual %h", e.coils, c);
                failures++;
            end
            if (md !== e.mode)
            begin
                $error("clock_mode: expected %0d, actual %0d", e.mode, md);
                failures++;
            end
            if (sp !== e.short_p)
            begin
                $error("short_press: expected %0d, actual %0d", e.short_p, sp);
                failures++;
            end
            if (lp !== e.long_p)
            begin
                $error("long_press: expected %0d, actual %0d", e.long_p, lp);
                failures++;
            end
            if (bz !== e.busy)
            begin
                $error("busy_res: expected %0d, actual %0d", e.busy, bz);
                failures++;
            end
        endfunction

        function int outstanding();
            return expected_ticks.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        button_level = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] coils;
    logic [1:0]  clock_mode;
    logic        short_press;
    logic        long_press;
    logic        busy_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    tick_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int items_sent = 0;
    int idle_cycles = 0;

    stepper_clock_controller_top #(
        .STEPS_REV(STEPS_REV)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .button_level(button_level),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .coils(coils),
        .clock_mode(clock_mode),
        .short_press(short_press),
        .long_press(long_press),
        .busy_res(busy_res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= 80;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_tick(button_level);
            if (out_valid && !out_stall)
                sb.check_tick(coils, clock_mode, short_press, long_press, busy_res);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input bit level);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        button_level <= level;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_ticks();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input bit [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, val);
        @(negedge clk);
    endtask

    task automatic apply_settings(input bit [15:0] deb, input bit [15:0] lp_ms,
                                  input bit [15:0] sd, input bit [15:0] mps);
        drain_ticks();
        cfg_write(CFG_DEBOUNCE, deb);
        cfg_write(CFG_LONG_PRESS, lp_ms);
        cfg_write(CFG_STEP_DELAY, sd);
        cfg_write(CFG_MS_PER_SEC, mps);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic play_presses(input int n_items, input int max_hold, input int max_gap);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 3)) send_item(1'($urandom_range(1)));
                repeat ($urandom_range(1, max_hold)) send_item(1'b1);
                repeat ($urandom_range(1, max_gap)) send_item(1'b0);
            end
            else
                repeat ($urandom_range(1, 8)) send_item(1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        bit warmup [6];
        bit presses [17];
        warmup = '{0, 1, 1, 0, 1, 0};
        presses = '{1, 0, 1, 1, 0, 1, 0, 0, 1, 0, 1, 1, 1, 0, 0, 1, 0};
        sb = new();
        send_idle_pct = 24;
        recv_idle_pct <= 49;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (warmup[i])
            send_item(warmup[i]);
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
        foreach (presses[i])
            send_item(presses[i]);

        apply_settings(16'd2, 16'd12, 16'd1, 16'd5);
        play_presses(120, 25, 10);

        send_idle_pct = 49;
        recv_idle_pct <= 24;
        apply_settings(16'd1, 16'd6, 16'd2, 16'd30);
        play_presses(120, 15, 6);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        apply_settings(16'd255, 16'd65535, 16'd255, 16'd1023);
        repeat (20) send_item(1'($urandom_range(1)));
        repeat (265) send_item(1'b1);

        apply_settings(16'd0, 16'd4, 16'd1, 16'd1);
        play_presses(100, 9, 5);
        hold_req <= hold_req + 1;
        play_presses(50, 9, 5);
        drain_ticks();
        play_presses(60, 9, 5);

        drain_ticks();
        repeat (8) @(negedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
